### design/tret_pkg.sv
// Shared types and constants for the tank refill and evaporation tracker.
// Holds the payload structs, register indexes and controller/datapath links.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tret_pkg;

	localparam int LEVEL_W   = 16;
	localparam int TOTAL_W   = 24;
	localparam int COUNT_W   = 16;
	localparam int SUM_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ACTION_W  = 2;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] FULL_Q15 = 16'h8000;
	localparam logic [TOTAL_W-1:0] MAX24    = 24'hFF_FFFF;
	localparam logic [COUNT_W-1:0] MAX16    = 16'hFFFF;
	localparam logic [SUM_W-1:0]   MAX32    = 32'hFFFF_FFFF;

	localparam logic [CFG_W-1:0] ECHO_SPAN_RST  = 16'd882;
	localparam logic [CFG_W-1:0] DEADBAND_RST   = 16'd328;
	localparam logic [CFG_W-1:0] FULL_LEVEL_RST = 16'd32113;

	localparam logic [CFG_IDX_W-1:0] REG_ECHO_SPAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = 2'd2;

	localparam logic [ACTION_W-1:0] ACT_READING  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUMP_ON  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PUMP_OFF = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [15:0]         echo_time;
	} item_t;

	typedef struct packed {
		logic               pump_on;
		logic [LEVEL_W-1:0] level;
		logic [TOTAL_W-1:0] refill_total;
		logic [TOTAL_W-1:0] evap_total;
		logic [COUNT_W-1:0] refill_cycles;
		logic [TOTAL_W-1:0] refill_average;
		logic [TOTAL_W-1:0] evap_average;
		logic               overflow_trip;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_close;
		logic account;
		logic pump_on;
		logic pump_off;
		logic set_trip;
		logic close_prep;
		logic close_fin;
		logic load_out;
	} tret_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                div_busy;
		logic                refill_open;
		logic                evap_open;
		logic                trip_hit;
		logic                out_free;
	} tret_sts_t;

endpackage

### design/tret_ctrl.sv
// Sequencing controller for the tank tracker.
// Walks each item through decode and, as its action needs, division, accounting and cycle closing.
// Depends on tret_pkg for the command and status structs.
`timescale 1ns / 1ps

module tret_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  tret_pkg::tret_sts_t sts,
	output tret_pkg::tret_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_LWAIT  = 9'b000000100,
		ST_ACCT   = 9'b000001000,
		ST_TRIP   = 9'b000010000,
		ST_CPREP  = 9'b000100000,
		ST_CSTART = 9'b001000000,
		ST_CWAIT  = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.action)
					tret_pkg::ACT_READING: begin
						cmd.div_start = 1'b1;
						state_d       = ST_LWAIT;
					end
					tret_pkg::ACT_PUMP_ON: begin
						cmd.pump_on = 1'b1;
						state_d     = sts.evap_open ? ST_CPREP : ST_DONE;
					end
					tret_pkg::ACT_PUMP_OFF: begin
						cmd.pump_off = 1'b1;
						state_d      = sts.refill_open ? ST_CPREP : ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_LWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_ACCT;
				end
			end
			ST_ACCT: begin
				cmd.account = 1'b1;
				state_d     = ST_TRIP;
			end
			ST_TRIP: begin
				if (sts.trip_hit) begin
					cmd.pump_off = 1'b1;
					cmd.set_trip = 1'b1;
					state_d      = sts.refill_open ? ST_CPREP : ST_DONE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CPREP: begin
				cmd.close_prep = 1'b1;
				state_d        = ST_CSTART;
			end
			ST_CSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_close = 1'b1;
				state_d       = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (!sts.div_busy) begin
					cmd.close_fin = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/tret_dp.sv
// Datapath of the tank tracker: registers, shared serial divider, result register.
// Acts only on commands from tret_ctrl and reports status back.
// Depends on tret_pkg for payload, command and status types.
`timescale 1ns / 1ps

module tret_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tret_pkg::tret_cmd_t                  cmd,
	output tret_pkg::tret_sts_t                  sts,
	input  tret_pkg::item_t                      item,
	input  logic                                 cfg_we,
	input  logic [tret_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tret_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output tret_pkg::result_t                    result
);

	localparam int LW = tret_pkg::LEVEL_W;
	localparam int TW = tret_pkg::TOTAL_W;
	localparam int CW = tret_pkg::COUNT_W;
	localparam int SW = tret_pkg::SUM_W;

	// Configuration registers.
	logic [tret_pkg::CFG_W-1:0] echo_span_q, deadband_q, full_level_q;

	// Captured item.
	logic [tret_pkg::ACTION_W-1:0] action_q;
	logic [15:0]                   echo_q;

	// Tracker state.
	logic          pump_q, first_q, trip_q, close_evap_q;
	logic [LW-1:0] prev_q;
	logic [TW-1:0] open_refill_q, open_evap_q;
	logic [CW-1:0] refill_cnt_q, evap_cnt_q;
	logic [SW-1:0] refill_sum_q, evap_sum_q;
	logic [TW-1:0] refill_avg_q, evap_avg_q;

	// Serial divider: one quotient bit a cycle, restoring.
	logic                           div_busy_q;
	logic [tret_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [15:0]                    div_rem_q;
	logic [SW-1:0]                  div_quo_q;
	logic [15:0]                    div_dsr_q;

	logic                 result_valid_q;
	tret_pkg::result_t    result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_span_q  <= tret_pkg::ECHO_SPAN_RST;
			deadband_q   <= tret_pkg::DEADBAND_RST;
			full_level_q <= tret_pkg::FULL_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tret_pkg::REG_ECHO_SPAN:  echo_span_q  <= cfg_wdata;
				tret_pkg::REG_DEADBAND:   deadband_q   <= cfg_wdata;
				tret_pkg::REG_FULL_LEVEL: full_level_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= item.action;
			echo_q   <= item.echo_time;
		end
	end

	// Divider operands.
	logic [15:0]   span_eff;
	logic [SW-1:0] div_dvd;
	logic [15:0]   div_dsr;
	logic [16:0]   div_trial;
	logic [16:0]   div_diff;
	logic          div_ge;

	assign span_eff  = (echo_span_q == '0) ? 16'd1 : echo_span_q;
	assign div_dvd   = cmd.div_close ? (close_evap_q ? evap_sum_q : refill_sum_q)
	                                 : {1'b0, echo_q, 15'd0};
	assign div_dsr   = cmd.div_close ? (close_evap_q ? evap_cnt_q : refill_cnt_q) : span_eff;
	assign div_trial = {div_rem_q, div_quo_q[SW-1]};
	assign div_diff  = div_trial - {1'b0, div_dsr_q};
	assign div_ge    = (div_trial >= {1'b0, div_dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (div_cnt_q == tret_pkg::DIV_CNT_W'(tret_pkg::DIV_STEPS - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= div_dvd;
			div_dsr_q <= div_dsr;
		end else if (div_busy_q) begin
			div_rem_q <= div_ge ? div_diff[15:0] : div_trial[15:0];
			div_quo_q <= {div_quo_q[SW-2:0], div_ge};
		end
	end

	// Level from the quotient, and the change against the previous level.
	logic [LW-1:0] lvl, prev_eff, rise, fall;
	logic          rise_ok, fall_ok;
	logic [TW:0]   refill_add, evap_add;

	assign lvl      = (div_quo_q >= SW'(tret_pkg::FULL_Q15)) ? '0
	                  : LW'(SW'(tret_pkg::FULL_Q15) - div_quo_q);
	assign prev_eff = first_q ? lvl : prev_q;
	assign rise     = lvl - prev_eff;
	assign fall     = prev_eff - lvl;
	assign rise_ok  = (lvl > prev_eff) && (rise > deadband_q);
	assign fall_ok  = (prev_eff > lvl) && (fall > deadband_q);
	assign refill_add = {1'b0, open_refill_q} + (TW+1)'(rise);
	assign evap_add   = {1'b0, open_evap_q} + (TW+1)'(fall);

	// Closing a cycle: saturating count and sum of the selected side.
	logic [TW-1:0] close_total;
	logic [CW-1:0] close_cnt;
	logic [SW-1:0] close_sum;
	logic [CW-1:0] cnt_next;
	logic [SW:0]   sum_add;
	logic [SW-1:0] sum_next;
	logic [TW-1:0] avg_next;

	assign close_total = close_evap_q ? open_evap_q : open_refill_q;
	assign close_cnt   = close_evap_q ? evap_cnt_q : refill_cnt_q;
	assign close_sum   = close_evap_q ? evap_sum_q : refill_sum_q;
	assign cnt_next    = (close_cnt == tret_pkg::MAX16) ? close_cnt : close_cnt + 1'b1;
	assign sum_add     = {1'b0, close_sum} + (SW+1)'(close_total);
	assign sum_next    = sum_add[SW] ? tret_pkg::MAX32 : sum_add[SW-1:0];
	assign avg_next    = (div_quo_q[SW-1:TW] != '0) ? tret_pkg::MAX24 : div_quo_q[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q        <= 1'b0;
			first_q       <= 1'b1;
			trip_q        <= 1'b0;
			close_evap_q  <= 1'b0;
			prev_q        <= '0;
			open_refill_q <= '0;
			open_evap_q   <= '0;
			refill_cnt_q  <= '0;
			evap_cnt_q    <= '0;
			refill_sum_q  <= '0;
			evap_sum_q    <= '0;
			refill_avg_q  <= '0;
			evap_avg_q    <= '0;
		end else begin
			if (cmd.capture) begin
				trip_q <= 1'b0;
			end
			if (cmd.set_trip) begin
				trip_q <= 1'b1;
			end
			// The side to close follows the latest pump change.
			if (cmd.pump_on) begin
				pump_q       <= 1'b1;
				close_evap_q <= 1'b1;
			end
			if (cmd.pump_off) begin
				pump_q       <= 1'b0;
				close_evap_q <= 1'b0;
			end
			if (cmd.account) begin
				first_q <= 1'b0;
				prev_q  <= lvl;
				if (pump_q && rise_ok) begin
					open_refill_q <= refill_add[TW] ? tret_pkg::MAX24 : refill_add[TW-1:0];
				end
				if (!pump_q && fall_ok) begin
					open_evap_q <= evap_add[TW] ? tret_pkg::MAX24 : evap_add[TW-1:0];
				end
			end
			if (cmd.close_prep) begin
				if (close_evap_q) begin
					evap_cnt_q  <= cnt_next;
					evap_sum_q  <= sum_next;
					open_evap_q <= '0;
				end else begin
					refill_cnt_q  <= cnt_next;
					refill_sum_q  <= sum_next;
					open_refill_q <= '0;
				end
			end
			if (cmd.close_fin) begin
				if (close_evap_q) begin
					evap_avg_q <= avg_next;
				end else begin
					refill_avg_q <= avg_next;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.pump_on        <= pump_q;
			result_q.level          <= prev_q;
			result_q.refill_total   <= open_refill_q;
			result_q.evap_total     <= open_evap_q;
			result_q.refill_cycles  <= refill_cnt_q;
			result_q.refill_average <= refill_avg_q;
			result_q.evap_average   <= evap_avg_q;
			result_q.overflow_trip  <= trip_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign sts.action      = action_q;
	assign sts.div_busy    = div_busy_q;
	assign sts.refill_open = (open_refill_q != '0);
	assign sts.evap_open   = (open_evap_q != '0);
	assign sts.trip_hit    = pump_q && (prev_q >= full_level_q);
	assign sts.out_free    = !result_valid_q || !result_stall;

endmodule

### design/tank_refill_evaporation_tracker.sv
// Top level of the tank refill and evaporation tracker.
// Instantiates the controller tret_ctrl and the datapath tret_dp; uses tret_pkg.
`timescale 1ns / 1ps

// The item channel carries one action per transfer: a sensor reading with its
// echo time, a pump on command or a pump off command. Every item gives exactly
// one result on the result channel, holding the pump drive, the level, the open
// totals, the refill cycle count and the held averages.
// One item is worked on at a time; item_stall is high from the transfer until
// the result has been written to the output register. A reading goes through
// the 32-step serial divider, which turns the echo time into a level; a pump
// command needs no division. When a command or a full-tank trip closes a
// cycle, the average needs a second pass of the same divider.
// The configuration port is a plain write port; writes are expected only while
// the block is idle and take effect at once.
// Reset clears the pump, the totals, counts, sums and averages, marks that no
// reading has been seen yet and loads the register defaults. The output
// register holds a result while result_stall is high; the block finishes its
// next item and then waits in its last step until the register is free.
module tank_refill_evaporation_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tret_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output tret_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [tret_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tret_pkg::CFG_W-1:0]     cfg_wdata
);

	tret_pkg::tret_cmd_t cmd;
	tret_pkg::tret_sts_t sts;

	// Sequencer: decides which step each item takes next.
	tret_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Storage, divider and result register.
	tret_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### design/tret_chk.sv
// Port-level checker for the tank tracker, bound to the top level.
// Depends on tret_pkg for the payload types.
`timescale 1ns / 1ps

module tret_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input tret_pkg::result_t result
);

	// A stalled result stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// One item at a time: the block is busy right after taking an item.
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while the previous one was in progress");

	// A trip always leaves the pump off.
	a_trip_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow_trip |-> !result.pump_on)
		else $error("trip reported with the pump still running");

	// The level never exceeds a full tank.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.level <= tret_pkg::FULL_Q15)
		else $error("level above full scale");

endmodule

bind tank_refill_evaporation_tracker tret_chk u_tret_chk (.*);
